>>> rtl/prl_pkg.sv
package prl_pkg;

	typedef struct packed {
		logic               kind;
		logic [7:0]         slot;
		logic               entry_valid;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [15:0] upward_sector;
		logic signed [15:0] downward_sector;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} req_t;

	typedef struct packed {
		logic               found;
		logic signed [15:0] sector;
	} rsp_t;

	// one table entry
	typedef struct packed {
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] ex;
		logic [31:0] ey;
		logic [15:0] up;
		logic [15:0] dn;
	} ent_t;

	// command to the shared shift/add unit
	typedef struct packed {
		logic start;
		logic mul;
	} alu_cmd_t;

	localparam int OPB_W  = 33;
	localparam int ACC_W  = 35;
	localparam int PROD_W = 66;
	localparam int THR_W  = 17;

	localparam logic [THR_W-1:0] THR_RESET = 17'd1;
	localparam logic [15:0]      NO_SECTOR = 16'hFFFF;
	localparam logic [31:0]      DIST_MAX  = 32'h7FFF_FFFF;
	localparam logic             KIND_WRITE = 1'b0;
	localparam logic [2:0]       ADDR_FLAT  = 3'd0;

endpackage

>>> rtl/prl_table.sv
module prl_table #(
	parameter int ENTRIES = 256,
	parameter int IW      = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [IW-1:0]     waddr,
	input  logic              wvalid,
	input  prl_pkg::ent_t     wdata,
	input  logic              re,
	input  logic [IW-1:0]     raddr,
	output prl_pkg::ent_t     rdata,
	output logic              rvalid
);

	prl_pkg::ent_t     mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvalid <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= wvalid;
			if (re)
				rvalid <= vld_q[raddr];
		end
	end

endmodule

>>> rtl/prl_alu.sv
module prl_alu #(
	parameter int NW = 49
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prl_pkg::alu_cmd_t   cmd,
	input  logic [NW-1:0]       opa,
	input  logic [prl_pkg::OPB_W-1:0] opb,
	output logic                done,
	output logic [((NW > prl_pkg::PROD_W) ? NW : prl_pkg::PROD_W)-1:0] result
);

	localparam int RW = (NW > prl_pkg::PROD_W) ? NW : prl_pkg::PROD_W;
	localparam int CW = $clog2(RW);
	localparam int BW = prl_pkg::OPB_W;
	localparam int AW = prl_pkg::ACC_W;

	logic          busy_q, mul_q;
	logic [CW-1:0] cnt_q;
	logic [BW:0]   rem_q;
	logic [RW-1:0] sh_q;
	logic [BW-1:0] opb_q;

	logic [CW-1:0] last;
	logic [AW-1:0] add_a, add_b, sum;
	logic          sub, ge;

	assign last = mul_q ? CW'(BW - 1) : CW'(NW - 1);
	assign done = busy_q && (cnt_q == last);

	// one adder serves both the restoring divide and the shift-add multiply
	always_comb begin
		if (mul_q) begin
			add_a = AW'(rem_q[BW-1:0]);
			add_b = sh_q[0] ? AW'(opb_q) : '0;
			sub   = 1'b0;
		end else begin
			add_a = AW'({rem_q[BW-1:0], sh_q[NW-1]});
			add_b = AW'(opb_q);
			sub   = 1'b1;
		end
		sum = add_a + (sub ? ~add_b : add_b) + AW'(sub);
		ge  = !sum[AW-1];
	end

	assign result = mul_q ? RW'({rem_q[BW-1:0], sh_q[BW-1:0]}) : RW'(sh_q[NW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			mul_q  <= cmd.mul;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			sh_q  <= RW'(opa);
			opb_q <= opb;
		end else if (busy_q) begin
			if (mul_q) begin
				rem_q <= {1'b0, sum[BW:1]};
				sh_q  <= {sh_q[RW-1:BW], sum[0], sh_q[BW-1:1]};
			end else begin
				rem_q <= ge ? sum[BW:0] : add_a[BW:0];
				sh_q  <= {sh_q[RW-2:0], ge};
			end
		end
	end

endmodule

>>> rtl/point_region_lookup_by_ray_core.sv
// Channel   Handshake              Word     Carries
// req       req_valid/req_ready    req      segment write or point query
// rsp       rsp_valid/rsp_ready    rsp      found flag and sector, one per query
// cfg       psel/penable/pwrite    pwdata   flat_threshold at byte address 0
//
// A query walks all TABLE_ENTRIES slots through one shared shift/add unit:
// a skipped slot passes RD, EVAL and NEXT, a flat one adds CMP, and an
// interpolated one runs DIV, QSAT, MGO, MUL, MSAT, SUM and CMP (bit-serial
// divide, then bit-serial multiply). DONE then posts the result.
// Reset clears the valid marks, the threshold (to 1) and all control state.
// req_ready is high only while idle; a finished result waits in the output
// register, and a later query stalls at its end until that word is taken.
module point_region_lookup_by_ray_core #(
	parameter int TABLE_ENTRIES = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  prl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output prl_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int NW = 33 + FRACTION_BITS;
	localparam int RW = (NW > prl_pkg::PROD_W) ? NW : prl_pkg::PROD_W;
	localparam int PW = prl_pkg::PROD_W + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_EVAL = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_QSAT = 4'd4;
	localparam logic [3:0] S_MGO  = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_MSAT = 4'd7;
	localparam logic [3:0] S_SUM  = 4'd8;
	localparam logic [3:0] S_CMP  = 4'd9;
	localparam logic [3:0] S_NEXT = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0] state_q;

	// configuration
	logic [prl_pkg::THR_W-1:0] thr_q;
	logic cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr == prl_pkg::ADDR_FLAT);
	assign prdata  = cfg_hit ? 32'(thr_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= prl_pkg::THR_RESET;
		else if (psel && penable && pwrite && pready && cfg_hit)
			thr_q <= pwdata[prl_pkg::THR_W-1:0];
	end

	// table
	logic          req_fire, tbl_we, tbl_re, ent_vld;
	prl_pkg::ent_t wr_ent, ent;
	logic [IW-1:0] idx_q;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign tbl_we    = req_fire && (req.kind == prl_pkg::KIND_WRITE) &&
	                   ({24'd0, req.slot} < 32'(TABLE_ENTRIES));
	assign tbl_re    = (state_q == S_RD);

	assign wr_ent.sx = req.start_x;
	assign wr_ent.sy = req.start_y;
	assign wr_ent.ex = req.end_x;
	assign wr_ent.ey = req.end_y;
	assign wr_ent.up = req.upward_sector;
	assign wr_ent.dn = req.downward_sector;

	prl_table #(.ENTRIES(TABLE_ENTRIES), .IW(IW)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tbl_we),
		.waddr  (IW'(req.slot)),
		.wvalid (req.entry_valid),
		.wdata  (wr_ent),
		.re     (tbl_re),
		.raddr  (idx_q),
		.rdata  (ent),
		.rvalid (ent_vld)
	);

	// shared shift/add unit
	prl_pkg::alu_cmd_t   alu_cmd;
	logic [NW-1:0]       alu_opa;
	logic [prl_pkg::OPB_W-1:0] alu_opb;
	logic                alu_done;
	logic [RW-1:0]       alu_res;

	prl_alu #(.NW(NW)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.opa    (alu_opa),
		.opb    (alu_opb),
		.done   (alu_done),
		.result (alu_res)
	);

	// scan registers
	logic signed [31:0] px_q, py_q, q_q, m_q;
	logic signed [33:0] dist_q;
	logic [31:0]        closest_q;
	logic [15:0]        best_q;
	logic               neg_q;

	// entry geometry, all differences exact in 33 bits
	logic signed [31:0] sx, sy, ex, ey;
	logic signed [32:0] dy, dx, da, db, d2;
	logic [32:0]        ady, adx, ad2, aq;
	logic               span, flat;
	logic signed [32:0] fmin;

	assign sx = ent.sx;
	assign sy = ent.sy;
	assign ex = ent.ex;
	assign ey = ent.ey;

	always_comb begin
		span = ((py_q >= sy) && (py_q < ey)) || ((py_q >= ey) && (py_q < sy));
		dy   = {sy[31], sy} - {ey[31], ey};
		dx   = {sx[31], sx} - {ex[31], ex};
		ady  = dy[32] ? 33'(-dy) : 33'(dy);
		adx  = dx[32] ? 33'(-dx) : 33'(dx);
		flat = (ady < 33'(thr_q));
		da   = {sx[31], sx} - {px_q[31], px_q};
		db   = {ex[31], ex} - {px_q[31], px_q};
		fmin = (da < db) ? da : db;
		d2   = {py_q[31], py_q} - {sy[31], sy};
		ad2  = d2[32] ? 33'(-d2) : 33'(d2);
		aq   = q_q[31] ? 33'(-{q_q[31], q_q}) : 33'({q_q[31], q_q});
	end

	// launch divide in EVAL, multiply in MGO
	always_comb begin
		alu_cmd.start = 1'b0;
		alu_cmd.mul   = 1'b0;
		alu_opa       = NW'(adx) << FRACTION_BITS;
		alu_opb       = ady;
		if (state_q == S_EVAL && ent_vld && span && !flat)
			alu_cmd.start = 1'b1;
		if (state_q == S_MGO) begin
			alu_cmd.start = 1'b1;
			alu_cmd.mul   = 1'b1;
			alu_opa       = NW'(ad2);
			alu_opb       = aq;
		end
	end

	// saturate the quotient and the shifted product to signed 32 bits
	logic [NW-1:0]      quo;
	logic signed [31:0] q_sat, m_sat;
	logic signed [PW-1:0] prod, prod_sh;

	always_comb begin
		quo = alu_res[NW-1:0];
		if (neg_q)
			q_sat = (quo > NW'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(quo[31:0]);
		else
			q_sat = (quo > NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);

		prod    = neg_q ? -$signed({1'b0, alu_res[prl_pkg::PROD_W-1:0]})
		                : $signed({1'b0, alu_res[prl_pkg::PROD_W-1:0]});
		prod_sh = prod >>> FRACTION_BITS;
		if (prod_sh > PW'(64'sh7FFF_FFFF))
			m_sat = 32'sh7FFF_FFFF;
		else if (prod_sh < -PW'(64'sh8000_0000))
			m_sat = 32'sh8000_0000;
		else
			m_sat = prod_sh[31:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready)
				rsp_valid <= 1'b0;
			if (state_q == S_DONE && !rsp_valid)
				rsp_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && !rsp_valid) begin
			rsp.found  <= !best_q[15];
			rsp.sector <= best_q[15] ? prl_pkg::NO_SECTOR : best_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && req.kind != prl_pkg::KIND_WRITE) begin
						idx_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD:   state_q <= S_EVAL;
				S_EVAL: begin
					if (!(ent_vld && span))
						state_q <= S_NEXT;
					else if (flat)
						state_q <= S_CMP;
					else
						state_q <= S_DIV;
				end
				S_DIV:  if (alu_done) state_q <= S_QSAT;
				S_QSAT: state_q <= S_MGO;
				S_MGO:  state_q <= S_MUL;
				S_MUL:  if (alu_done) state_q <= S_MSAT;
				S_MSAT: state_q <= S_SUM;
				S_SUM:  state_q <= S_CMP;
				S_CMP:  state_q <= S_NEXT;
				S_NEXT: begin
					if (idx_q == IW'(TABLE_ENTRIES - 1)) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_RD;
					end
				end
				S_DONE: if (!rsp_valid) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q      <= req.point_x;
				py_q      <= req.point_y;
				closest_q <= prl_pkg::DIST_MAX;
				best_q    <= prl_pkg::NO_SECTOR;
			end
			S_EVAL: begin
				dist_q <= {fmin[32], fmin};
				neg_q  <= dx[32] ^ dy[32];
			end
			S_QSAT: q_q <= q_sat;
			S_MGO:  neg_q <= q_q[31] ^ d2[32];
			S_MSAT: m_q <= m_sat;
			S_SUM:  dist_q <= {{2{m_q[31]}}, m_q} + {{2{sx[31]}}, sx} -
			                  {{2{px_q[31]}}, px_q};
			S_CMP: begin
				// keep the nearest crossing to the right; ties hold the lower slot
				if (dist_q > 34'sd0 && dist_q < $signed({2'b00, closest_q})) begin
					closest_q <= dist_q[31:0];
					best_q    <= (sy < ey) ? ent.up : ent.dn;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> tb/sv/point_region_lookup_by_ray_checker.sv
module point_region_lookup_by_ray_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  prl_pkg::req_t  req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  prl_pkg::rsp_t  rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic           pready,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output int             errors,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  SLOTS = 256;
	localparam int  FRAC  = 16;
	localparam longint REACH_LIMIT = 64'sd2147483647;

	logic [prl_pkg::THR_W-1:0] flat_thr;
	logic             live [SLOTS];
	logic [31:0]      seg_sx [SLOTS];
	logic [31:0]      seg_sy [SLOTS];
	logic [31:0]      seg_ex [SLOTS];
	logic [31:0]      seg_ey [SLOTS];
	logic [15:0]      seg_up [SLOTS];
	logic [15:0]      seg_dn [SLOTS];
	prl_pkg::rsp_t    sector_queue [$];

	function automatic longint clamp32(longint v);
		if (v > REACH_LIMIT) return REACH_LIMIT;
		if (v < -REACH_LIMIT - 1) return -REACH_LIMIT - 1;
		return v;
	endfunction

	// cast a ray to the right and return the sector behind the nearest wall
	function automatic prl_pkg::rsp_t locate_sector(logic signed [31:0] px_in,
			logic signed [31:0] py_in);
		longint px, py, x1, y1, x2, y2, dy, ady, reach, q, m, a, b, closest, best;
		prl_pkg::rsp_t r;
		px = px_in;
		py = py_in;
		closest = REACH_LIMIT;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!live[i]) continue;
			x1 = longint'(signed'(seg_sx[i]));
			y1 = longint'(signed'(seg_sy[i]));
			x2 = longint'(signed'(seg_ex[i]));
			y2 = longint'(signed'(seg_ey[i]));
			if (!((py >= y1 && py < y2) || (py >= y2 && py < y1))) continue;
			dy = y1 - y2;
			ady = dy < 0 ? -dy : dy;
			if (ady < longint'(flat_thr)) begin
				a = x1 - px;
				b = x2 - px;
				reach = a < b ? a : b;
			end else begin
				if (dy == 0) continue;
				q = clamp32(((x1 - x2) * (64'sd1 << FRAC)) / dy);
				m = clamp32((q * (py - y1)) >>> FRAC);
				reach = m + x1 - px;
			end
			if (reach > 0 && reach < closest) begin
				closest = reach;
				best = (y1 < y2) ? longint'(signed'(seg_up[i])) : longint'(signed'(seg_dn[i]));
			end
		end
		if (best < 0) begin
			r.found = 1'b0;
			r.sector = prl_pkg::NO_SECTOR;
		end else begin
			r.found = 1'b1;
			r.sector = best[15:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_thr = prl_pkg::THR_RESET;
			for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
			sector_queue.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == prl_pkg::ADDR_FLAT)
				flat_thr = pwdata[prl_pkg::THR_W-1:0];
			if (req_valid && req_ready) begin
				if (req.kind == prl_pkg::KIND_WRITE) begin
					seg_sx[req.slot] = req.start_x;
					seg_sy[req.slot] = req.start_y;
					seg_ex[req.slot] = req.end_x;
					seg_ey[req.slot] = req.end_y;
					seg_up[req.slot] = req.upward_sector;
					seg_dn[req.slot] = req.downward_sector;
					live[req.slot] = req.entry_valid;
				end else begin
					sector_queue.push_back(locate_sector(req.point_x, req.point_y));
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (sector_queue.size() == 0) begin
					$error("unexpected result word found=%0d sector=%0d", rsp.found, rsp.sector);
					errors++;
				end else begin
					prl_pkg::rsp_t exp_w;
					exp_w = sector_queue.pop_front();
					if (rsp.found !== exp_w.found) begin
						$error("found: expected %0d actual %0d", exp_w.found, rsp.found);
						errors++;
					end
					if (rsp.sector !== exp_w.sector) begin
						$error("sector: expected %0d actual %0d", exp_w.sector, rsp.sector);
						errors++;
					end
				end
			end
			pending = sector_queue.size();
		end
	end
endmodule

>>> tb/sv/point_region_lookup_by_ray_core_test.sv
module point_region_lookup_by_ray_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 300000;
	localparam int MAX_LIVE = 12;
	localparam int SPAN = 64 << 16;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	prl_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	prl_pkg::rsp_t rsp;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [2:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;
	int            errors;
	int            pending;
	int            stall_free = 0;
	int            idle_cycles = 0;
	logic          slot_live [256];
	int            live_count = 0;

	always #6 clk = ~clk;

	point_region_lookup_by_ray_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	point_region_lookup_by_ray_checker checker_u (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	// stall the result side with a chance of 28 in 100, except in the stall-free stretch
	always @(posedge clk)
		rsp_ready <= (stall_free != 0) ? 1'b1 : ($urandom_range(99) >= 28);

	// abort when no word moves on any port for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic prl_pkg::req_t seg_word(logic [7:0] slot, logic ev, int sx, int sy,
			int ex, int ey, logic [15:0] up, logic [15:0] dn);
		prl_pkg::req_t w;
		w = '0;
		w.kind = prl_pkg::KIND_WRITE;
		w.slot = slot;
		w.entry_valid = ev;
		w.start_x = sx;
		w.start_y = sy;
		w.end_x = ex;
		w.end_y = ey;
		w.upward_sector = up;
		w.downward_sector = dn;
		w.point_x = $urandom();
		w.point_y = $urandom();
		return w;
	endfunction

	function automatic prl_pkg::req_t query_word(int px, int py);
		prl_pkg::req_t w;
		w = seg_word(8'($urandom()), 1'($urandom()), $urandom(), $urandom(), $urandom(),
			$urandom(), 16'($urandom()), 16'($urandom()));
		w.kind = ~prl_pkg::KIND_WRITE;
		w.point_x = px;
		w.point_y = py;
		return w;
	endfunction

	// hold valid high across back-to-back words; drop it only for an idle gap
	task automatic send(prl_pkg::req_t w);
		if (stall_free == 0 && $urandom_range(99) < 28) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (w.kind == prl_pkg::KIND_WRITE) begin
			if (slot_live[w.slot] && !w.entry_valid) live_count--;
			if (!slot_live[w.slot] && w.entry_valid) live_count++;
			slot_live[w.slot] = w.entry_valid;
		end
	endtask

	// drain all results, let the block settle, then write the threshold
	task automatic set_threshold(logic [31:0] v);
		req_valid <= 1'b0;
		@(posedge clk);
		while (!(pending == 0 && req_ready)) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= prl_pkg::ADDR_FLAT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic int near_coord();
		return $signed($urandom_range(0, 2 * SPAN)) - SPAN;
	endfunction

	function automatic logic [15:0] rand_sector();
		int r;
		r = $urandom_range(9);
		if (r < 2) return prl_pkg::NO_SECTOR;
		if (r < 8) return 16'($urandom_range(32767));
		return 16'($urandom());
	endfunction

	// mostly small well-formed segments near the origin; keep the live set small
	task automatic random_phase(int count);
		int r;
		logic [7:0] s;
		logic ev;
		for (int n = 0; n < count; n++) begin
			if (n == count / 3) stall_free = 1;
			if (n == count / 3 + 60) stall_free = 0;
			r = $urandom_range(99);
			if (r < 35) begin
				if ($urandom_range(9) == 0)
					send(query_word($urandom(), $urandom()));
				else
					send(query_word(near_coord(), near_coord()));
			end else if (r < 75) begin
				s = 8'($urandom_range(15));
				ev = slot_live[s] || live_count < MAX_LIVE;
				send(seg_word(s, ev, near_coord(), near_coord(), near_coord(), near_coord(),
					rand_sector(), rand_sector()));
			end else if (r < 88) begin
				send(seg_word(8'($urandom()), 1'b0, $urandom(), $urandom(), $urandom(),
					$urandom(), 16'($urandom()), 16'($urandom())));
			end else begin
				s = 8'($urandom());
				ev = slot_live[s] || live_count < MAX_LIVE;
				if ($urandom_range(1))
					send(seg_word(s, ev, $urandom(), $urandom(), $urandom(), $urandom(),
						rand_sector(), rand_sector()));
				else
					send(seg_word(s, ev, near_coord(), near_coord(), near_coord(),
						near_coord(), rand_sector(), rand_sector()));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 256; i++) slot_live[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then a simple upward wall to the right of the origin
		send(query_word(0, 0));
		send(seg_word(8'd0, 1'b1, 10 << 16, -5 << 16, 10 << 16, 5 << 16, 16'd3, 16'd7));
		send(query_word(0, 0));
		// upper end of the span is excluded, lower end included
		send(query_word(0, 5 << 16));
		send(query_word(0, -5 << 16));
		// downward wall in the top slot, then a tie in slot 1 where the lower slot wins
		send(seg_word(8'd255, 1'b1, 4 << 16, 5 << 16, 4 << 16, -5 << 16, prl_pkg::NO_SECTOR,
			16'd32767));
		send(query_word(0, 0));
		send(seg_word(8'd1, 1'b1, 4 << 16, 5 << 16, 4 << 16, -5 << 16, 16'd2, 16'd9));
		send(query_word(0, 0));
		// nearest wall carries a negative sector
		send(seg_word(8'd2, 1'b1, 2 << 16, -5 << 16, 2 << 16, 5 << 16, 16'h8000, 16'd1));
		send(query_word(0, 0));
		// point to the right of every wall
		send(query_word(100 << 16, 0));
		// slope saturates on a near-flat steep wall
		send(seg_word(8'd3, 1'b1, 32'h7FFF_FFFF, 0, 32'h8000_0000, 1, 16'd11, 16'd12));
		send(query_word(32'h8000_0000, 0));
		// product saturates on a full-range diagonal
		send(seg_word(8'd4, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			16'd21, 16'd22));
		send(query_word(-100, 0));
		send(query_word(32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send(query_word(32'h8000_0000, 32'h8000_0000));
		// an invalid write hides an entry
		send(seg_word(8'd2, 1'b0, 2 << 16, -5 << 16, 2 << 16, 5 << 16, 16'd1, 16'd1));
		send(query_word(0, 0));

		// flat walls: the endpoint minimum stands in for the crossing
		set_threshold(32'd65536);
		send(seg_word(8'd5, 1'b1, 3 << 16, 0, 1 << 16, 100, 16'd30, 16'd31));
		send(query_word(0, 50));
		send(query_word(0, 0));
		for (int i = 0; i < 256; i++)
			if (slot_live[i])
				send(seg_word(8'(i), 1'b0, 0, 0, 0, 0, 16'd0, 16'd0));

		set_threshold(32'd0);
		random_phase(230);
		set_threshold(32'd65536);
		random_phase(230);
		set_threshold(32'd1);
		random_phase(120);
		set_threshold($urandom_range(2, 65535));
		random_phase(120);

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

>>> point_region_lookup_by_ray_core.f
rtl/prl_pkg.sv
rtl/prl_table.sv
rtl/prl_alu.sv
rtl/point_region_lookup_by_ray_core.sv
tb/sv/point_region_lookup_by_ray_checker.sv
tb/sv/point_region_lookup_by_ray_core_test.sv
